### rtl/core/cmdtrk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Command tracker package
// Shared types and constants for the command tracker: field widths, item function
// codes, slot status codes, configuration register indexes, reset values and controller commands.
// ----------------------------------------------------------------------------
package cmdtrk_pkg;

    // Field widths fixed by the interface.
    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 3;
    localparam int STATUS_W = 3;
    localparam int TMASK_W  = 8;
    localparam int TIME_W   = 32;
    localparam int TMO_W    = 16;
    localparam int WMASK_W  = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MASK = 1'd1;

    // Register reset values.
    localparam logic [TMO_W-1:0]   TIMEOUT_RESET   = 16'd5;
    localparam logic [WMASK_W-1:0] WAIT_MASK_RESET = 8'd15;

    // Item function codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_SEND      = 3'd0,
        FN_ACK_OK    = 3'd1,
        FN_ACK_ERR   = 3'd2,
        FN_EVT_DONE  = 3'd3,
        FN_EVT_ERR   = 3'd4,
        FN_TICK      = 3'd5,
        FN_QUERY     = 3'd6,
        FN_CLEAR_ALL = 3'd7
    } func_t;

    // Slot status codes.
    typedef enum logic [STATUS_W-1:0] {
        SS_IDLE        = 3'd0,
        SS_WAIT_ACK    = 3'd1,
        SS_WAIT_RESULT = 3'd2,
        SS_DONE        = 3'd3,
        SS_FAILED      = 3'd4,
        SS_TIMED_OUT   = 3'd5
    } slot_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // Load the input item registers.
        logic execute;   // Apply the held item and load the result register.
    } dp_cmd_t;

endpackage : cmdtrk_pkg
`default_nettype wire

### rtl/core/command_tracker_with_timeout.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Command tracker with timeout
// Tracks a set of command slots through send, ack, result event and timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ channel (s_func, s_cmd_index) with valid/ready, and
//   each item gives exactly one result on the m_ channel (m_slot_status,
//   m_accepted, m_timed_out_mask). A transfer happens when valid and ready
//   are both high at a rising edge of aclk.
//   An item is first captured into the held item registers, then, once the
//   result register is free, applied to the slot registers while the result
//   register is loaded. The sequencer takes a new item only after the held
//   item is applied; the item hold stage and the update stage set this.
//   A tick compares all slots against the timeout in parallel.
//   When the receiver stalls, the result waits in the output register and
//   one further item may be taken and held; it is applied once the waiting
//   result is transferred.
//   The configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes the
//   timeout (index 0) or the result wait mask (index 1).
//   Synchronous reset clears all slots to idle, the seconds counter to zero,
//   the timeout to 5 and the wait mask to 15, and drops any pending result.
// ----------------------------------------------------------------------------
module command_tracker_with_timeout
    import cmdtrk_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [FUNC_W-1:0]     s_func,
    input  wire logic [INDEX_W-1:0]    s_cmd_index,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [STATUS_W-1:0]        m_slot_status,
    output logic                       m_accepted,
    output logic [TMASK_W-1:0]         m_timed_out_mask,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t dp_cmd;

    // Sequencer.
    cmdtrk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd)
    );

    // Slot registers and result.
    cmdtrk_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .dp_cmd           (dp_cmd),
        .s_func           (s_func),
        .s_cmd_index      (s_cmd_index),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .m_slot_status    (m_slot_status),
        .m_accepted       (m_accepted),
        .m_timed_out_mask (m_timed_out_mask)
    );

endmodule : command_tracker_with_timeout
`default_nettype wire

### rtl/core/cmdtrk_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Command tracker controller
// Two-state sequencer that takes an item, then applies it once the result
// register is free, and keeps the result valid flag.
// ----------------------------------------------------------------------------
module cmdtrk_ctrl
    import cmdtrk_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output dp_cmd_t      dp_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    // The result register may be loaded when empty or emptied in this cycle.
    assign out_free       = !m_valid_reg || m_ready;
    assign s_ready        = (state_reg == S_IDLE);
    assign dp_cmd.capture = s_valid && (state_reg == S_IDLE);
    assign dp_cmd.execute = (state_reg == S_EXEC) && out_free;
    assign m_valid        = m_valid_reg;

    // Next state and result valid flag.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A captured item always moves to the execute state next.
    a_capture_exec : assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.capture |=> (state_reg == S_EXEC))
        else $error("captured item did not move to execute");

    // Applying an item always presents a result.
    a_exec_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.execute |=> m_valid)
        else $error("executed item produced no result");

    // A stalled result is never dropped.
    a_hold_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("stalled result was lost");

    // Capture and execute never coincide.
    a_no_overlap : assert property (@(posedge aclk) disable iff (!aresetn)
        !(dp_cmd.capture && dp_cmd.execute))
        else $error("capture and execute in the same cycle");

endmodule : cmdtrk_ctrl
`default_nettype wire

### rtl/core/cmdtrk_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Command tracker datapath
// Slot status, active and stamp registers, the seconds counter, configuration
// registers, the held input item and the result register.
// ----------------------------------------------------------------------------
module cmdtrk_datapath
    import cmdtrk_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               dp_cmd,
    input  wire logic [FUNC_W-1:0]     s_func,
    input  wire logic [INDEX_W-1:0]    s_cmd_index,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic [STATUS_W-1:0]        m_slot_status,
    output logic                       m_accepted,
    output logic [TMASK_W-1:0]         m_timed_out_mask
);

    // Configuration and time base.
    logic [TMO_W-1:0]   timeout_reg;
    logic [WMASK_W-1:0] wait_mask_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  now_next;

    // Slot storage.
    slot_status_t      state_reg  [NUM_SLOTS];
    slot_status_t      state_next [NUM_SLOTS];
    logic              active_reg [NUM_SLOTS];
    logic              active_next[NUM_SLOTS];
    logic [TIME_W-1:0] stamp_reg  [NUM_SLOTS];
    logic [TIME_W-1:0] stamp_next [NUM_SLOTS];

    // Held item.
    func_t              func_reg;
    logic [INDEX_W-1:0] index_reg;

    // Result register.
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                accepted_reg;
    logic                accepted_next;
    logic [TMASK_W-1:0]  tmask_reg;
    logic [TMASK_W-1:0]  tmask_next;

    logic               index_ok;
    logic               hit;
    logic               wait_bit;
    logic [TIME_W-1:0]  elapsed;

    assign index_ok = (int'(index_reg) < NUM_SLOTS);

    // Slot update for the held item. The timeout test uses the elapsed time
    // before the tick: after the increment it exceeds the limit exactly when
    // the old value reaches the limit and does not wrap to zero.
    always_comb begin
        now_next      = now_reg;
        accepted_next = 1'b0;
        tmask_next    = '0;
        hit           = 1'b0;
        wait_bit      = 1'b0;
        elapsed       = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            state_next[i]  = state_reg[i];
            active_next[i] = active_reg[i];
            stamp_next[i]  = stamp_reg[i];
        end
        if (func_reg == FN_TICK) begin
            now_next = now_reg + TIME_W'(1);
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            hit      = index_ok && (int'(index_reg) == i);
            wait_bit = (i < WMASK_W) ? wait_mask_reg[i[2:0]] : 1'b0;
            elapsed  = now_reg - stamp_reg[i];
            unique case (func_reg)
                FN_SEND: begin
                    if (hit && state_reg[i] != SS_WAIT_ACK
                            && state_reg[i] != SS_WAIT_RESULT) begin
                        active_next[i] = 1'b1;
                        state_next[i]  = SS_WAIT_ACK;
                        stamp_next[i]  = now_reg;
                        accepted_next  = 1'b1;
                    end
                end
                FN_ACK_OK: begin
                    if (hit) begin
                        if (wait_bit) begin
                            state_next[i] = SS_WAIT_RESULT;
                            stamp_next[i] = now_reg;
                        end else begin
                            state_next[i]  = SS_DONE;
                            active_next[i] = 1'b0;
                        end
                    end
                end
                FN_ACK_ERR: begin
                    if (hit) begin
                        state_next[i]  = SS_FAILED;
                        active_next[i] = 1'b0;
                    end
                end
                FN_EVT_DONE, FN_EVT_ERR: begin
                    if (hit && active_reg[i]) begin
                        state_next[i]  = (func_reg == FN_EVT_DONE) ? SS_DONE : SS_FAILED;
                        active_next[i] = 1'b0;
                    end
                end
                FN_TICK: begin
                    if (active_reg[i] && elapsed >= {{(TIME_W-TMO_W){1'b0}}, timeout_reg}
                            && elapsed != '1) begin
                        state_next[i]  = SS_TIMED_OUT;
                        active_next[i] = 1'b0;
                        if (i < TMASK_W) begin
                            tmask_next[i[2:0]] = 1'b1;
                        end
                    end
                end
                FN_QUERY: begin
                end
                FN_CLEAR_ALL: begin
                    state_next[i]  = SS_IDLE;
                    active_next[i] = 1'b0;
                    stamp_next[i]  = '0;
                end
            endcase
        end
    end

    // Status of the addressed slot after the update.
    always_comb begin
        status_next = SS_IDLE;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (index_ok && int'(index_reg) == i) begin
                status_next = state_next[i];
            end
        end
    end

    // Control state: slots, time base and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TIMEOUT_RESET;
            wait_mask_reg <= WAIT_MASK_RESET;
            now_reg       <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                state_reg[i]  <= SS_IDLE;
                active_reg[i] <= 1'b0;
            end
        end else begin
            if (cfg_wr_en) begin
                priority if (cfg_index == CFG_TIMEOUT) begin
                    timeout_reg <= cfg_wdata[TMO_W-1:0];
                end else if (cfg_index == CFG_WAIT_MASK) begin
                    wait_mask_reg <= cfg_wdata[WMASK_W-1:0];
                end
            end
            if (dp_cmd.execute) begin
                now_reg <= now_next;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    state_reg[i]  <= state_next[i];
                    active_reg[i] <= active_next[i];
                end
            end
        end
    end

    // Payload registers: stamps, held item and result.
    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            func_reg  <= func_t'(s_func);
            index_reg <= s_cmd_index;
        end
        if (dp_cmd.execute) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                stamp_reg[i] <= stamp_next[i];
            end
            status_reg   <= status_next;
            accepted_reg <= accepted_next;
            tmask_reg    <= tmask_next;
        end
    end

    assign m_slot_status    = status_reg;
    assign m_accepted       = accepted_reg;
    assign m_timed_out_mask = tmask_reg;

endmodule : cmdtrk_datapath
`default_nettype wire
